FILE: rtl/core/csoc_pkg.sv
// Shared types, codes and constants of the cell state-of-charge estimator.
package csoc_pkg;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MAX_CHARGE = 2'd0,
		CFG_TICK_MS    = 2'd1,
		CFG_TABLE_LEN  = 2'd2
	} cfg_idx_t;

	localparam logic [15:0] MAX_CHARGE_RST = 16'd2600;
	localparam logic [15:0] TICK_MS_RST    = 16'd1000;
	localparam logic [4:0]  TABLE_LEN_RST  = 5'd16;

	// Command codes
	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_CAL  = 2'd1,
		CMD_TICK = 2'd2
	} cmd_t;

	// mA*ms per mAh per percent
	localparam logic [15:0] CAL_SCALE    = 16'd36000;
	// soc = charge / (360 * capacity_mah); divisor pre-shifted for a 14-bit quotient
	localparam logic [21:0] DSH_SCALE    = 22'd2949120;
	// 360 * 10001: charge at or above this times capacity clamps to full
	localparam logic [21:0] LIM_SCALE    = 22'd3600360;
	localparam logic [13:0] SOC_FULL     = 14'd10000;
	localparam logic [13:0] SOC_PER_PCT  = 14'd100;
	localparam logic [6:0]  PCT_FULL     = 7'd100;
	localparam logic [3:0]  DIV_LAST_BIT = 4'd13;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [2:0]         cell_index;
		logic [15:0]        voltage_mv;
		logic [3:0]         table_index;
		logic [6:0]         table_level;
		logic signed [15:0] current_ma;
	} item_t;

	typedef struct packed {
		logic [2:0]         cell_id;
		logic [13:0]        soc_centi;
		logic signed [39:0] charge_mams;
		logic               matched;
		logic               clamped;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [15:0] max_charge_mah;
		logic [15:0] tick_ms;
		logic [4:0]  table_len;
	} cfg_t;

	typedef struct packed {
		logic [15:0] volt;
		logic [6:0]  level;
	} tbl_entry_t;

	// Datapath operations driven by the control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_TBL_WR,
		OP_J_CLR,
		OP_J_INC,
		OP_LOAD_CHG,
		OP_MUL_CAP,
		OP_MUL_LEV,
		OP_MUL_TICK,
		OP_SUB_SAT,
		OP_DIV_INIT,
		OP_SET_CLAMP,
		OP_DIV_STEP,
		OP_EMIT
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_TBL_EMPTY,
		C_MATCH,
		C_MORE_ENTRIES,
		C_CLAMP_HIT,
		C_DIV_MORE,
		C_MORE_CELLS
	} cond_t;

	typedef logic [3:0] upc_t;

	// Microprogram addresses
	localparam upc_t UPC_IDLE      = 4'd0;
	localparam upc_t UPC_LOAD      = 4'd1;
	localparam upc_t UPC_CAL_INIT  = 4'd2;
	localparam upc_t UPC_CAL_RD    = 4'd3;
	localparam upc_t UPC_CAL_CMP   = 4'd4;
	localparam upc_t UPC_CAL_NEXT  = 4'd5;
	localparam upc_t UPC_NOMATCH   = 4'd6;
	localparam upc_t UPC_CAL_HIT   = 4'd7;
	localparam upc_t UPC_CAL_LEV   = 4'd8;
	localparam upc_t UPC_TICK_INIT = 4'd9;
	localparam upc_t UPC_TICK_LD   = 4'd10;
	localparam upc_t UPC_SOC_INIT  = 4'd11;
	localparam upc_t UPC_SOC_CLAMP = 4'd12;
	localparam upc_t UPC_SOC_DIV   = 4'd13;
	localparam upc_t UPC_EMIT      = 4'd14;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
		logic  done;
	} uword_t;

	typedef struct packed {
		logic tbl_empty;
		logic match;
		logic more_entries;
		logic clamp_hit;
		logic div_more;
		logic more_cells;
	} status_t;

endpackage

FILE: rtl/core/cell_soc_estimator.sv
// Per-cell state-of-charge estimator: OCV table lookup and coulomb counting.
//
// Command channel: item is taken at a rising edge with start high and busy low;
// busy stays high while the command runs and the last result word of the
// command stands in the first cycle with busy low again.
// Load writes one table entry and gives no word. Calibrate gives one word
// for the addressed cell; tick gives one word per cell, cell 0 first, last set
// on the final one. Calibrate with a cell index beyond the cell count and the
// unused command code give nothing and leave busy low.
// Result channel: each word stands for one cycle with result_valid high;
// the receiver cannot hold it off.
// A calibrate hit takes the SOC from the table level; a calibrate miss and each
// tick cell take it from the charge. The table scan reads the single memory port
// once per entry, and an SOC from the charge takes one pass of a 14-step
// restoring divider unless it clamps.
// Configuration writes land at once; the user makes them only while busy is low,
// and the block does not enforce it. Reset clears the charges and loads the
// default registers; the table holds nothing useful until loaded.
module cell_soc_estimator #(
	parameter int NUM_CELLS   = 5,
	parameter int TABLE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  csoc_pkg::item_t    item,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               result_valid,
	output csoc_pkg::result_t  result
);

	csoc_pkg::cfg_t    cfg_q;
	csoc_pkg::status_t status;
	csoc_pkg::op_t     op;
	logic              accept;

	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_charge_mah <= csoc_pkg::MAX_CHARGE_RST;
			cfg_q.tick_ms        <= csoc_pkg::TICK_MS_RST;
			cfg_q.table_len      <= csoc_pkg::TABLE_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				csoc_pkg::CFG_MAX_CHARGE: cfg_q.max_charge_mah <= cfg_data;
				csoc_pkg::CFG_TICK_MS:    cfg_q.tick_ms        <= cfg_data;
				csoc_pkg::CFG_TABLE_LEN:  cfg_q.table_len      <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	csoc_sequencer #(
		.NUM_CELLS (NUM_CELLS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.status (status),
		.op     (op),
		.busy   (busy)
	);

	csoc_datapath #(
		.NUM_CELLS   (NUM_CELLS),
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.item         (item),
		.cfg          (cfg_q),
		.op           (op),
		.status       (status),
		.result       (result),
		.result_valid (result_valid)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result word without a command in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result word after the last word of a command");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.soc_centi <= csoc_pkg::SOC_FULL)
		else $error("soc above full scale");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> result.matched)
		else $error("unmatched word inside a tick burst");

endmodule

FILE: rtl/core/csoc_ucode_rom.sv
// Control store: one control word per microprogram step.
module csoc_ucode_rom (
	input  csoc_pkg::upc_t   upc,
	output csoc_pkg::uword_t uword
);

	always_comb begin
		case (upc)
			csoc_pkg::UPC_IDLE: uword = '{csoc_pkg::OP_NOP, csoc_pkg::C_NEVER,
				csoc_pkg::UPC_IDLE, 1'b0};
			csoc_pkg::UPC_LOAD: uword = '{csoc_pkg::OP_TBL_WR, csoc_pkg::C_NEVER,
				csoc_pkg::UPC_IDLE, 1'b1};
			csoc_pkg::UPC_CAL_INIT: uword = '{csoc_pkg::OP_J_CLR, csoc_pkg::C_TBL_EMPTY,
				csoc_pkg::UPC_NOMATCH, 1'b0};
			csoc_pkg::UPC_CAL_RD: uword = '{csoc_pkg::OP_NOP, csoc_pkg::C_NEVER,
				csoc_pkg::UPC_IDLE, 1'b0};
			csoc_pkg::UPC_CAL_CMP: uword = '{csoc_pkg::OP_NOP, csoc_pkg::C_MATCH,
				csoc_pkg::UPC_CAL_HIT, 1'b0};
			csoc_pkg::UPC_CAL_NEXT: uword = '{csoc_pkg::OP_J_INC, csoc_pkg::C_MORE_ENTRIES,
				csoc_pkg::UPC_CAL_RD, 1'b0};
			csoc_pkg::UPC_NOMATCH: uword = '{csoc_pkg::OP_LOAD_CHG, csoc_pkg::C_ALWAYS,
				csoc_pkg::UPC_SOC_INIT, 1'b0};
			csoc_pkg::UPC_CAL_HIT: uword = '{csoc_pkg::OP_MUL_CAP, csoc_pkg::C_NEVER,
				csoc_pkg::UPC_IDLE, 1'b0};
			csoc_pkg::UPC_CAL_LEV: uword = '{csoc_pkg::OP_MUL_LEV, csoc_pkg::C_ALWAYS,
				csoc_pkg::UPC_EMIT, 1'b0};
			csoc_pkg::UPC_TICK_INIT: uword = '{csoc_pkg::OP_MUL_TICK, csoc_pkg::C_NEVER,
				csoc_pkg::UPC_IDLE, 1'b0};
			csoc_pkg::UPC_TICK_LD: uword = '{csoc_pkg::OP_SUB_SAT, csoc_pkg::C_NEVER,
				csoc_pkg::UPC_IDLE, 1'b0};
			csoc_pkg::UPC_SOC_INIT: uword = '{csoc_pkg::OP_DIV_INIT, csoc_pkg::C_NEVER,
				csoc_pkg::UPC_IDLE, 1'b0};
			csoc_pkg::UPC_SOC_CLAMP: uword = '{csoc_pkg::OP_SET_CLAMP, csoc_pkg::C_CLAMP_HIT,
				csoc_pkg::UPC_EMIT, 1'b0};
			csoc_pkg::UPC_SOC_DIV: uword = '{csoc_pkg::OP_DIV_STEP, csoc_pkg::C_DIV_MORE,
				csoc_pkg::UPC_SOC_DIV, 1'b0};
			csoc_pkg::UPC_EMIT: uword = '{csoc_pkg::OP_EMIT, csoc_pkg::C_MORE_CELLS,
				csoc_pkg::UPC_TICK_LD, 1'b1};
			default: uword = '{csoc_pkg::OP_NOP, csoc_pkg::C_ALWAYS,
				csoc_pkg::UPC_IDLE, 1'b0};
		endcase
	end

endmodule

FILE: rtl/core/csoc_sequencer.sv
// Microprogram sequencer: step counter, command dispatch and conditional jumps.
module csoc_sequencer #(
	parameter int NUM_CELLS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  csoc_pkg::item_t     item,
	input  csoc_pkg::status_t   status,
	output csoc_pkg::op_t       op,
	output logic                busy
);

	csoc_pkg::upc_t   pc_q;
	csoc_pkg::upc_t   pc_next;
	csoc_pkg::uword_t uw;
	logic             cond_hit;
	logic             cell_ok;

	csoc_ucode_rom u_rom (
		.upc   (pc_q),
		.uword (uw)
	);

	assign cell_ok = 5'(item.cell_index) < 5'(NUM_CELLS);
	assign op      = uw.op;
	assign busy    = pc_q != csoc_pkg::UPC_IDLE;

	always_comb begin
		case (uw.cond)
			csoc_pkg::C_NEVER:        cond_hit = 1'b0;
			csoc_pkg::C_ALWAYS:       cond_hit = 1'b1;
			csoc_pkg::C_TBL_EMPTY:    cond_hit = status.tbl_empty;
			csoc_pkg::C_MATCH:        cond_hit = status.match;
			csoc_pkg::C_MORE_ENTRIES: cond_hit = status.more_entries;
			csoc_pkg::C_CLAMP_HIT:    cond_hit = status.clamp_hit;
			csoc_pkg::C_DIV_MORE:     cond_hit = status.div_more;
			csoc_pkg::C_MORE_CELLS:   cond_hit = status.more_cells;
			default:                  cond_hit = 1'b0;
		endcase
	end

	always_comb begin
		pc_next = csoc_pkg::UPC_IDLE;
		if (!busy) begin
			if (accept) begin
				case (item.cmd)
					csoc_pkg::CMD_LOAD: pc_next = csoc_pkg::UPC_LOAD;
					csoc_pkg::CMD_CAL:  pc_next = cell_ok ? csoc_pkg::UPC_CAL_INIT
						: csoc_pkg::UPC_IDLE;
					csoc_pkg::CMD_TICK: pc_next = csoc_pkg::UPC_TICK_INIT;
					default:            pc_next = csoc_pkg::UPC_IDLE;
				endcase
			end
		end else if (cond_hit) begin
			pc_next = uw.target;
		end else if (uw.done) begin
			pc_next = csoc_pkg::UPC_IDLE;
		end else begin
			pc_next = csoc_pkg::upc_t'(pc_q + 4'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= csoc_pkg::UPC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

FILE: rtl/core/csoc_table_ram.sv
// Voltage/level table memory, one write port and one registered read port.
module csoc_table_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [AW-1:0]          waddr,
	input  csoc_pkg::tbl_entry_t   wdata,
	input  logic [AW-1:0]          raddr,
	output csoc_pkg::tbl_entry_t   rdata
);

	csoc_pkg::tbl_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/csoc_datapath.sv
// Datapath: table scan, charge accumulators, multiplier and restoring divider.
module csoc_datapath #(
	parameter int NUM_CELLS   = 5,
	parameter int TABLE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  csoc_pkg::item_t     item,
	input  csoc_pkg::cfg_t      cfg,
	input  csoc_pkg::op_t       op,
	output csoc_pkg::status_t   status,
	output csoc_pkg::result_t   result,
	output logic                result_valid
);

	localparam int CIW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int NW  = ($clog2(TABLE_DEPTH + 1) > 5) ? $clog2(TABLE_DEPTH + 1) : 5;

	localparam logic signed [39:0] CHG_MAX = {1'b0, {39{1'b1}}};
	localparam logic signed [39:0] CHG_MIN = {1'b1, {39{1'b0}}};

	csoc_pkg::item_t      item_q;
	csoc_pkg::result_t    result_q;
	csoc_pkg::tbl_entry_t rd_data;
	csoc_pkg::tbl_entry_t wr_data;
	logic                 result_valid_q;
	logic [CIW-1:0]       i_q;
	logic [AW-1:0]        j_q;
	logic [3:0]           cnt_q;
	logic signed [39:0]   acc_q;
	logic signed [32:0]   d_q;
	logic [37:0]          dsh_q;
	logic [37:0]          lim_q;
	logic [39:0]          rem_q;
	logic [13:0]          soc_q;
	logic                 clamp_q;
	logic                 matched_q;
	logic signed [39:0]   charge_q [NUM_CELLS];

	logic [15:0]          m_eff;
	logic [NW-1:0]        n_used;
	logic [NW-1:0]        j_plus;
	logic                 is_tick;
	logic                 last_cell;
	logic                 tbl_we;
	logic signed [39:0]   cur_charge;
	logic signed [40:0]   diff;
	logic signed [39:0]   diff_sat;
	logic [31:0]          cap_prod;
	logic [38:0]          lev_prod;
	logic signed [32:0]   tick_prod;
	logic [37:0]          dsh_prod;
	logic [37:0]          lim_prod;
	logic [39:0]          trial;
	logic                 div_ge;
	logic [13:0]          lev_soc;
	logic                 lev_over;

	assign m_eff     = (cfg.max_charge_mah == '0) ? 16'd1 : cfg.max_charge_mah;
	assign n_used    = (NW'(cfg.table_len) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
		: NW'(cfg.table_len);
	assign j_plus    = NW'(j_q) + NW'(1);
	assign is_tick   = item_q.cmd == csoc_pkg::CMD_TICK;
	assign last_cell = i_q == CIW'(NUM_CELLS - 1);
	assign tbl_we    = (op == csoc_pkg::OP_TBL_WR)
		&& (NW'(item_q.table_index) < NW'(TABLE_DEPTH));
	assign wr_data   = '{volt: item_q.voltage_mv, level: item_q.table_level};

	csoc_table_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (AW'(item_q.table_index)),
		.wdata (wr_data),
		.raddr (j_q),
		.rdata (rd_data)
	);

	assign cur_charge = charge_q[i_q];
	assign diff       = 41'(cur_charge) - 41'(d_q);

	always_comb begin
		case (diff[40:39])
			2'b01:   diff_sat = CHG_MAX;
			2'b10:   diff_sat = CHG_MIN;
			default: diff_sat = diff[39:0];
		endcase
	end

	assign cap_prod  = 32'(m_eff) * 32'(csoc_pkg::CAL_SCALE);
	assign lev_prod  = 39'(acc_q[31:0]) * 39'(rd_data.level);
	assign tick_prod = 33'(item_q.current_ma) * signed'(33'(cfg.tick_ms));
	assign dsh_prod  = 38'(m_eff) * 38'(csoc_pkg::DSH_SCALE);
	assign lim_prod  = 38'(m_eff) * 38'(csoc_pkg::LIM_SCALE);
	assign trial     = 40'(dsh_q);
	assign div_ge    = rem_q >= trial;
	assign lev_over  = rd_data.level > csoc_pkg::PCT_FULL;
	assign lev_soc   = lev_over ? csoc_pkg::SOC_FULL
		: 14'(14'(rd_data.level) * csoc_pkg::SOC_PER_PCT);

	assign status.tbl_empty    = n_used == '0;
	assign status.match        = item_q.voltage_mv >= rd_data.volt;
	assign status.more_entries = j_plus < n_used;
	assign status.clamp_hit    = acc_q[39] | (acc_q[38:0] >= 39'(lim_q));
	assign status.div_more     = cnt_q != '0;
	assign status.more_cells   = is_tick & ~last_cell;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			cnt_q          <= '0;
		end else begin
			result_valid_q <= op == csoc_pkg::OP_EMIT;
			if (load) begin
				i_q <= (item.cmd == csoc_pkg::CMD_TICK) ? '0 : CIW'(item.cell_index);
			end
			case (op)
				csoc_pkg::OP_J_CLR:    j_q   <= '0;
				csoc_pkg::OP_J_INC:    j_q   <= AW'(j_plus);
				csoc_pkg::OP_DIV_INIT: cnt_q <= csoc_pkg::DIV_LAST_BIT;
				csoc_pkg::OP_DIV_STEP: cnt_q <= cnt_q - 4'd1;
				csoc_pkg::OP_EMIT: begin
					if (is_tick && !last_cell) begin
						i_q <= i_q + CIW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// per-cell charge accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CELLS; k++) begin
				charge_q[k] <= '0;
			end
		end else if (op == csoc_pkg::OP_EMIT) begin
			charge_q[i_q] <= acc_q;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load) begin
			item_q    <= item;
			matched_q <= item.cmd == csoc_pkg::CMD_TICK;
		end
		case (op)
			csoc_pkg::OP_LOAD_CHG: acc_q <= cur_charge;
			csoc_pkg::OP_MUL_CAP:  acc_q <= signed'(40'(cap_prod));
			csoc_pkg::OP_MUL_LEV: begin
				acc_q     <= signed'(40'(lev_prod));
				soc_q     <= lev_soc;
				clamp_q   <= lev_over;
				matched_q <= 1'b1;
			end
			csoc_pkg::OP_MUL_TICK: d_q <= tick_prod;
			csoc_pkg::OP_SUB_SAT:  acc_q <= diff_sat;
			csoc_pkg::OP_DIV_INIT: begin
				dsh_q <= dsh_prod;
				lim_q <= lim_prod;
				rem_q <= acc_q;
			end
			csoc_pkg::OP_SET_CLAMP: begin
				clamp_q <= status.clamp_hit;
				soc_q   <= acc_q[39] ? '0 : csoc_pkg::SOC_FULL;
			end
			csoc_pkg::OP_DIV_STEP: begin
				// one quotient bit per step, divisor walks right
				if (div_ge) begin
					rem_q <= rem_q - trial;
				end
				soc_q <= {soc_q[12:0], div_ge};
				dsh_q <= dsh_q >> 1;
			end
			csoc_pkg::OP_EMIT: begin
				result_q.cell_id     <= 3'(i_q);
				result_q.soc_centi   <= soc_q;
				result_q.charge_mams <= acc_q;
				result_q.matched     <= matched_q;
				result_q.clamped     <= clamp_q;
				result_q.last        <= ~is_tick | last_cell;
			end
			default: ;
		endcase
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule
